### src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tlv_pkg.sv
// Shared types, codes and tag table for the TLV record parser.
// No dependencies.
`timescale 1ns / 1ps

package tlv_pkg;

    localparam int IMAGE_BYTES_DEF = 128;
    localparam int FIELD_BYTES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2,
        PH_HALT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_VALUE = 2'd0,
        ST_EMPTY = 2'd1,
        ST_HALT  = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    localparam logic [3:0] KIND_CHECKSUM  = 4'd0;
    localparam logic [3:0] KIND_HWTYPE    = 4'd1;
    localparam logic [3:0] KIND_PLATFORMS = 4'd2;
    localparam logic [3:0] KIND_DIRECTIVE = 4'd3;
    localparam logic [3:0] KIND_PART      = 4'd4;
    localparam logic [3:0] KIND_SERIAL    = 4'd5;
    localparam logic [3:0] KIND_DATE      = 4'd6;
    localparam logic [3:0] KIND_ASSEMBLY  = 4'd7;
    localparam logic [3:0] KIND_CLEI      = 4'd8;

    localparam logic [7:0] TAG_CHECKSUM  = 8'h00;
    localparam logic [7:0] TAG_HWTYPE    = 8'h01;
    localparam logic [7:0] TAG_PLATFORMS = 8'h03;
    localparam logic [7:0] TAG_DIRECTIVE = 8'h05;
    localparam logic [7:0] TAG_PART      = 8'h15;
    localparam logic [7:0] TAG_SERIAL    = 8'h16;
    localparam logic [7:0] TAG_DATE      = 8'h17;
    localparam logic [7:0] TAG_ASSEMBLY  = 8'h1b;
    localparam logic [7:0] TAG_CLEI      = 8'h1a;

    localparam logic [7:0] DIRECTIVE_BYTES = 8'd4;

    // Classified byte handed from the parser to the result stage.
    typedef struct packed {
        logic [3:0] kind;
        t_status    status;
        logic [7:0] idx;
        logic [7:0] value;
        logic       rec_end;
    } t_evt;

    typedef struct packed {
        logic       known;
        logic [3:0] kind;
    } t_tag_info;

    function automatic t_tag_info tag_lookup(input logic [7:0] tag);
        t_tag_info info;
        info.known = 1'b1;
        case (tag)
            TAG_CHECKSUM:  info.kind = KIND_CHECKSUM;
            TAG_HWTYPE:    info.kind = KIND_HWTYPE;
            TAG_PLATFORMS: info.kind = KIND_PLATFORMS;
            TAG_DIRECTIVE: info.kind = KIND_DIRECTIVE;
            TAG_PART:      info.kind = KIND_PART;
            TAG_SERIAL:    info.kind = KIND_SERIAL;
            TAG_DATE:      info.kind = KIND_DATE;
            TAG_ASSEMBLY:  info.kind = KIND_ASSEMBLY;
            TAG_CLEI:      info.kind = KIND_CLEI;
            default: begin
                info.known = 1'b0;
                info.kind  = KIND_CHECKSUM;
            end
        endcase
        return info;
    endfunction

endpackage

### src/tlv_front.sv
// Parse state machine: classifies accepted bytes, some into result events.
// Depends on tlv_pkg.
`timescale 1ns / 1ps

module tlv_front
    import tlv_pkg::*;
#(
    parameter int IMAGE_BYTES = IMAGE_BYTES_DEF,
    parameter int FIELD_BYTES = FIELD_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_image_start,
    output logic       o_evt_valid,
    output t_evt       o_evt
);

    localparam int         PW      = $clog2(IMAGE_BYTES + 1);
    localparam logic [PW-1:0] POS_LIMIT = PW'(IMAGE_BYTES);
    localparam logic [7:0] STR_CAP = 8'(FIELD_BYTES - 1);

    t_phase        r_phase, n_phase;
    logic [3:0]    r_kind, n_kind;
    logic [7:0]    r_left, n_left;
    logic [7:0]    r_vpos, n_vpos;
    logic [PW-1:0] r_pos, n_pos;

    t_phase        e_phase;
    logic [PW-1:0] e_pos;
    logic          live;
    t_tag_info     tag;
    logic [7:0]    left_dec;
    logic [7:0]    cap;

    // image_start restarts the parse on this very byte
    always_comb begin
        e_phase  = i_image_start ? PH_TAG : r_phase;
        e_pos    = i_image_start ? '0 : r_pos;
        live     = i_accept && (e_pos < POS_LIMIT);
        tag      = tag_lookup(i_data_byte);
        left_dec = (r_left != 8'd0) ? r_left - 8'd1 : 8'd0;
        if (r_kind == KIND_DIRECTIVE) begin
            cap = DIRECTIVE_BYTES;
        end else if (r_kind <= KIND_PLATFORMS) begin
            cap = 8'd1;
        end else begin
            cap = STR_CAP;
        end
    end

    // next state
    always_comb begin
        n_phase = i_accept ? e_phase : r_phase;
        if (live) begin
            case (e_phase)
                PH_TAG: begin
                    if (!tag.known) begin
                        n_phase = PH_HALT;
                    end else if (tag.kind == KIND_HWTYPE) begin
                        n_phase = PH_VAL;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN:  n_phase = (i_data_byte == 8'd0) ? PH_TAG : PH_VAL;
                PH_VAL:  n_phase = (left_dec == 8'd0) ? PH_TAG : PH_VAL;
                PH_HALT: n_phase = PH_HALT;
                default: n_phase = PH_TAG;
            endcase
        end
    end

    // datapath and event outputs
    always_comb begin
        n_kind          = r_kind;
        n_left          = r_left;
        n_vpos          = r_vpos;
        n_pos           = i_accept ? e_pos : r_pos;
        o_evt_valid     = 1'b0;
        o_evt.kind      = r_kind;
        o_evt.status    = ST_VALUE;
        o_evt.idx       = r_vpos;
        o_evt.value     = i_data_byte;
        o_evt.rec_end   = 1'b0;
        if (live) begin
            n_pos = e_pos + PW'(1);
            case (e_phase)
                PH_TAG: begin
                    n_vpos = 8'd0;
                    if (!tag.known) begin
                        o_evt_valid  = 1'b1;
                        o_evt.kind   = KIND_CHECKSUM;
                        o_evt.status = ST_HALT;
                        o_evt.idx    = 8'd0;
                    end else begin
                        n_kind = tag.kind;
                        if (tag.kind == KIND_HWTYPE) begin
                            n_left = 8'd1;
                        end
                    end
                end
                PH_LEN: begin
                    n_vpos = 8'd0;
                    n_left = i_data_byte;
                    if (i_data_byte == 8'd0) begin
                        o_evt_valid   = 1'b1;
                        o_evt.status  = ST_EMPTY;
                        o_evt.idx     = 8'd0;
                        o_evt.value   = 8'd0;
                        o_evt.rec_end = 1'b1;
                    end
                end
                PH_VAL: begin
                    o_evt_valid   = 1'b1;
                    o_evt.status  = (r_vpos < cap) ? ST_VALUE : ST_OVER;
                    o_evt.rec_end = (left_dec == 8'd0);
                    n_left        = left_dec;
                    n_vpos        = (r_vpos == 8'hff) ? r_vpos : r_vpos + 8'd1;
                end
                PH_HALT: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_kind  <= '0;
            r_left  <= '0;
            r_vpos  <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_left  <= n_left;
            r_vpos  <= n_vpos;
            r_pos   <= n_pos;
        end
    end

endmodule

### src/tlv_evq.sv
// Small event queue between the parser and the result stage.
// Depends on tlv_pkg.
`timescale 1ns / 1ps

module tlv_evq
    import tlv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_evt,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_evt o_evt
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_evt          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_evt   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### src/tlv_back.sv
// Result stage: directive word assembly and the output register.
// Depends on tlv_pkg.
`timescale 1ns / 1ps

module tlv_back
    import tlv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_evt        i_q_evt,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [3:0]  o_record_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_byte_index,
    output logic [7:0]  o_value_byte,
    output logic        o_record_end,
    output logic [31:0] o_word_value
);

    logic        r_valid;
    logic [31:0] r_acc, n_acc;
    logic [4:0]  shift;
    logic [31:0] contrib;
    logic [31:0] base;
    logic        load;

    assign load    = i_q_valid && (!r_valid || i_pop);
    assign o_q_pop = load;
    assign o_empty = !r_valid;

    // big-endian, left-aligned: byte 0 lands in bits 31:24
    always_comb begin
        shift   = 5'd24 - {i_q_evt.idx[1:0], 3'b000};
        contrib = {24'd0, i_q_evt.value} << shift;
        base    = (i_q_evt.idx == 8'd0) ? 32'd0 : r_acc;
        n_acc   = base;
        if (i_q_evt.kind == KIND_DIRECTIVE && i_q_evt.status == ST_VALUE) begin
            n_acc = base | contrib;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_acc         <= n_acc;
            o_record_kind <= i_q_evt.kind;
            o_status      <= i_q_evt.status;
            o_byte_index  <= i_q_evt.idx;
            o_value_byte  <= i_q_evt.value;
            o_record_end  <= i_q_evt.rec_end;
            o_word_value  <= (i_q_evt.kind == KIND_DIRECTIVE) ? n_acc : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

### src/tlv_eeprom_record_parser_top.sv
// Top level of the TLV identity-memory record parser.
// Depends on tlv_pkg, tlv_front, tlv_evq and tlv_back.
`timescale 1ns / 1ps

// Splits an identity-memory image, fed one byte per item, into
// tag-length-value records. A byte is taken on every cycle in which push
// is high and full is low, and results leave at one per cycle while pop
// is held and empty is low: the rate is one item per clock, set by the
// parse state machine in the front end, which handles each byte as it is
// taken. The parser classifies a byte combinationally as it is taken and
// writes its event into the queue register; the output register then
// loads it from the queue once the output is empty or being popped.
// Bytes that cause no result (known tags, nonzero length bytes, bytes
// past IMAGE_BYTES or after an unknown-tag halt) are still taken.
// full rises only when the QUEUE_DEPTH-entry event queue is full, i.e.
// when the consumer has stopped popping. image_start on a byte restarts
// the parse with that byte taken as a tag. Status codes: value byte,
// empty record end, unknown tag halt, overflow byte (value bytes past
// the field capacity, still reported). word_value carries the
// directive word assembled so far for kind 3 and is zero otherwise.
module tlv_eeprom_record_parser_top
    import tlv_pkg::*;
#(
    parameter int IMAGE_BYTES = IMAGE_BYTES_DEF,
    parameter int FIELD_BYTES = FIELD_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_image_start,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_record_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_byte_index,
    output logic [7:0]  o_value_byte,
    output logic        o_record_end,
    output logic [31:0] o_word_value
);

    logic accept;
    logic evt_valid;
    t_evt evt;
    logic q_valid;
    t_evt q_evt;
    logic q_pop;

    // a byte is only taken when its possible event has a slot
    assign accept = push && !full;

    tlv_front #(
        .IMAGE_BYTES(IMAGE_BYTES),
        .FIELD_BYTES(FIELD_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_image_start(i_image_start),
        .o_evt_valid  (evt_valid),
        .o_evt        (evt)
    );

    tlv_evq #(
        .DEPTH(QUEUE_DEPTH)
    ) u_evq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (evt_valid),
        .i_evt  (evt),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_full (full),
        .o_evt  (q_evt)
    );

    tlv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_evt      (q_evt),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_record_kind(o_record_kind),
        .o_status     (o_status),
        .o_byte_index (o_byte_index),
        .o_value_byte (o_value_byte),
        .o_record_end (o_record_end),
        .o_word_value (o_word_value)
    );

endmodule

### src/tlv_chk.sv
// Port-level checker for the TLV record parser, bound to the top level.
// Depends on tlv_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlv_chk
    import tlv_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  i_data_byte,
    input logic        i_image_start,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  o_record_kind,
    input logic [1:0]  o_status,
    input logic [7:0]  o_byte_index,
    input logic [7:0]  o_value_byte,
    input logic        o_record_end,
    input logic [31:0] o_word_value
);

    `ASSERT_IMPLIES(a_halt_fields, i_clk, i_rst_n, !empty && o_status == ST_HALT, o_record_kind == KIND_CHECKSUM && o_byte_index == 8'd0 && !o_record_end && o_word_value == 32'd0, "halt item carries nonzero fields")
    `ASSERT_IMPLIES(a_empty_rec, i_clk, i_rst_n, !empty && o_status == ST_EMPTY, o_record_end && o_byte_index == 8'd0 && o_value_byte == 8'd0 && o_word_value == 32'd0, "malformed empty record marker")
    `ASSERT_IMPLIES(a_word_kind, i_clk, i_rst_n, !empty && o_record_kind != KIND_DIRECTIVE, o_word_value == 32'd0, "word value on a non-directive item")
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_value_byte) && $stable(o_status) && $stable(o_word_value), "result changed while stalled")

endmodule

bind tlv_eeprom_record_parser_top tlv_chk u_chk (.*);
